// ===== sv/fpra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fpra_pkg;

  localparam int NUM_RESOURCES_DEF  = 8;
  localparam int NUM_REQUESTERS_DEF = 16;
  localparam int QUEUE_DEPTH        = 16;
  localparam int QSLOT_W            = 4;
  localparam int ID_W               = 4;
  localparam int IDX_W              = 4;
  localparam int KIND_W             = 2;
  localparam int STATUS_W           = 2;
  localparam int CNT_W              = 5;
  localparam int TIME_W             = 32;
  localparam int COOL_W             = 16;
  localparam int MAX_GRANTS         = 4;
  localparam int NGR_W              = 3;
  localparam int PADDR_W            = 3;
  localparam int PDATA_W            = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQ  = 2'd0,
    KIND_REL  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EQUAL = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BUSY_FREE = 2'd0,
    BUSY_USED = 2'd1,
    BUSY_COOL = 2'd2
  } busy_t;

  typedef struct packed {
    logic             tick;
    logic             rel;
    logic             grant;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
  } res_cmd_t;

endpackage
`default_nettype wire

// ===== sv/fpra_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fpra_in_if import fpra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   requester_id;
  logic [IDX_W-1:0]  left_index;
  logic [IDX_W-1:0]  right_index;
  modport source (output valid, kind, requester_id, left_index, right_index, input ready);
  modport sink   (input valid, kind, requester_id, left_index, right_index, output ready);
endinterface

interface fpra_out_if import fpra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                is_grant;
  logic [ID_W-1:0]     granted_id;
  logic [STATUS_W-1:0] status;
  logic                last;
  modport source (output valid, is_grant, granted_id, status, last, input ready);
  modport sink   (input valid, is_grant, granted_id, status, last, output ready);
endinterface
`default_nettype wire

// ===== sv/fpra_qram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fpra_qram import fpra_pkg::*; #(
  parameter int DEPTH = NUM_RESOURCES_DEF * QUEUE_DEPTH,
  parameter int AW    = 7
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire logic [ID_W-1:0] wdata,
  input  wire logic [AW-1:0]   raddr,
  output logic      [ID_W-1:0] rdata
);

  logic [ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/fpra_res.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fpra_res import fpra_pkg::*; #(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int RIDX_W        = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire res_cmd_t          cmd,
  input  wire logic [COOL_W-1:0] cooldown,
  input  wire logic [RIDX_W-1:0] qa,
  input  wire logic [RIDX_W-1:0] qb,
  output logic                   free_a,
  output logic                   free_b
);

  busy_t             busy     [NUM_RESOURCES];
  logic [TIME_W-1:0] deadline [NUM_RESOURCES];
  logic [TIME_W-1:0] time_now;
  logic [TIME_W:0]   dl_sum;
  logic [TIME_W-1:0] dl;
  logic [RIDX_W-1:0] ca, cb;

  assign ca     = cmd.a[RIDX_W-1:0];
  assign cb     = cmd.b[RIDX_W-1:0];
  assign dl_sum = {1'b0, time_now} + (TIME_W + 1)'(cooldown);
  assign dl     = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

  // expired cooldown counts as free
  assign free_a = (busy[qa] == BUSY_FREE) ||
                  ((busy[qa] == BUSY_COOL) && (deadline[qa] <= time_now));
  assign free_b = (busy[qb] == BUSY_FREE) ||
                  ((busy[qb] == BUSY_COOL) && (deadline[qb] <= time_now));

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        busy[r]     <= BUSY_FREE;
        deadline[r] <= '0;
      end
    end else begin
      if (cmd.tick && (time_now != '1)) begin
        time_now <= time_now + TIME_W'(1);
      end
      if (cmd.rel) begin
        busy[ca]     <= BUSY_COOL;
        busy[cb]     <= BUSY_COOL;
        deadline[ca] <= dl;
        deadline[cb] <= dl;
      end
      if (cmd.grant) begin
        busy[ca] <= BUSY_USED;
        busy[cb] <= BUSY_USED;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/fifo_paired_resource_arbiter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A request is enqueued in two steps (accept, second push); other kinds are taken at once.
// Each grant pass visits every resource, in one to four steps each (head read, pending
// lookup, two head compares), until four grants are made; a grant beat follows each
// grant, and one status beat closes the item. An output stall holds the core at either beat.
// The core takes one item at a time: input is ready only while idle.
// Reset clears queue pointers, resource state and time at once; no clearing pass.
module fifo_paired_resource_arbiter_core import fpra_pkg::*; #(
  parameter int NUM_RESOURCES  = NUM_RESOURCES_DEF,
  parameter int NUM_REQUESTERS = NUM_REQUESTERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  fpra_in_if.sink                 in_ch,
  fpra_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int RA_W   = RIDX_W + QSLOT_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PUSH2 = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_GETID = 8'b0000_1000,
    S_CHKA  = 8'b0001_0000,
    S_CHKB  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_STAT  = 8'b1000_0000
  } state_t;

  state_t              st, st_next, adv_st;
  logic [RIDX_W-1:0]   scan_i, scan_i_next, adv_i;
  logic                progress, progress_next, adv_prog;
  logic [NGR_W-1:0]    ngr, ngr_next;
  status_t             stat, stat_next;
  logic [ID_W-1:0]     cur_id, cur_id_next;
  logic [RIDX_W-1:0]   cur_a, cur_a_next, cur_b, cur_b_next;
  logic [QSLOT_W-1:0]  head       [NUM_RESOURCES];
  logic [QSLOT_W-1:0]  head_next  [NUM_RESOURCES];
  logic [CNT_W-1:0]    count      [NUM_RESOURCES];
  logic [CNT_W-1:0]    count_next [NUM_RESOURCES];
  logic [RIDX_W-1:0]   pend_l [NUM_REQUESTERS];
  logic [RIDX_W-1:0]   pend_r [NUM_REQUESTERS];
  logic                pend_we;
  logic [COOL_W-1:0]   cooldown;

  logic                mem_we;
  logic [RA_W-1:0]     mem_waddr, mem_raddr;
  logic [ID_W-1:0]     mem_wdata, mem_rdata;
  res_cmd_t            cmd;
  logic                free_a, free_b;

  logic                slot_free, out_load, out_grant;
  logic                idx_ok;
  logic [RIDX_W-1:0]   la, lb, pa, pb;
  kind_t               kind;

  assign kind      = kind_t'(in_ch.kind);
  assign la        = in_ch.left_index[RIDX_W-1:0];
  assign lb        = in_ch.right_index[RIDX_W-1:0];
  assign idx_ok    = ({1'b0, in_ch.requester_id} < (ID_W + 1)'(NUM_REQUESTERS)) &&
                     ({1'b0, in_ch.left_index}   < (IDX_W + 1)'(NUM_RESOURCES)) &&
                     ({1'b0, in_ch.right_index}  < (IDX_W + 1)'(NUM_RESOURCES));
  assign pa        = pend_l[mem_rdata];
  assign pb        = pend_r[mem_rdata];
  assign in_ch.ready = (st == S_IDLE);
  assign slot_free = !out_ch.valid || out_ch.ready;

  // next resource in the pass, or at its end a new pass if it granted anything, else the status beat
  always_comb begin
    adv_st   = S_SCAN;
    adv_i    = scan_i + RIDX_W'(1);
    adv_prog = progress;
    if (scan_i == RIDX_W'(NUM_RESOURCES - 1)) begin
      adv_i    = '0;
      adv_prog = 1'b0;
      adv_st   = progress ? S_SCAN : S_STAT;
    end
  end

  always_comb begin
    st_next       = st;
    scan_i_next   = scan_i;
    progress_next = progress;
    ngr_next      = ngr;
    stat_next     = stat;
    cur_id_next   = cur_id;
    cur_a_next    = cur_a;
    cur_b_next    = cur_b;
    head_next     = head;
    count_next    = count;
    pend_we       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    cmd           = '0;
    out_load      = 1'b0;
    out_grant     = 1'b0;
    unique case (st)
      S_IDLE: begin
        if (in_ch.valid) begin
          scan_i_next   = '0;
          progress_next = 1'b0;
          ngr_next      = '0;
          stat_next     = ST_OK;
          st_next       = S_SCAN;
          if ((kind == KIND_REQ) || (kind == KIND_REL)) begin
            if (!idx_ok) begin
              stat_next = ST_RANGE;
            end else if (in_ch.left_index == in_ch.right_index) begin
              stat_next = ST_EQUAL;
            end else if (kind == KIND_REQ) begin
              if ((count[la] >= CNT_W'(QUEUE_DEPTH)) ||
                  (count[lb] >= CNT_W'(QUEUE_DEPTH))) begin
                stat_next = ST_FULL;
              end else begin
                pend_we        = 1'b1;
                mem_we         = 1'b1;
                mem_waddr      = {la, head[la] + count[la][QSLOT_W-1:0]};
                mem_wdata      = in_ch.requester_id;
                count_next[la] = count[la] + CNT_W'(1);
                cur_id_next    = in_ch.requester_id;
                cur_b_next     = lb;
                st_next        = S_PUSH2;
              end
            end else begin
              cmd.rel = 1'b1;
              cmd.a   = in_ch.left_index;
              cmd.b   = in_ch.right_index;
            end
          end else if (kind == KIND_TICK) begin
            cmd.tick = 1'b1;
          end
        end
      end
      S_PUSH2: begin
        mem_we            = 1'b1;
        mem_waddr         = {cur_b, head[cur_b] + count[cur_b][QSLOT_W-1:0]};
        mem_wdata         = cur_id;
        count_next[cur_b] = count[cur_b] + CNT_W'(1);
        st_next           = S_SCAN;
      end
      S_SCAN: begin
        if (ngr == NGR_W'(MAX_GRANTS)) begin
          st_next = S_STAT;
        end else if (count[scan_i] == '0) begin
          st_next       = adv_st;
          scan_i_next   = adv_i;
          progress_next = adv_prog;
        end else begin
          mem_raddr = {scan_i, head[scan_i]};
          st_next   = S_GETID;
        end
      end
      S_GETID: begin
        cur_id_next = mem_rdata;
        cur_a_next  = pa;
        cur_b_next  = pb;
        if ((pa == pb) || (count[pa] == '0)) begin
          st_next       = adv_st;
          scan_i_next   = adv_i;
          progress_next = adv_prog;
        end else begin
          mem_raddr = {pa, head[pa]};
          st_next   = S_CHKA;
        end
      end
      S_CHKA: begin
        if ((mem_rdata != cur_id) || (count[cur_b] == '0)) begin
          st_next       = adv_st;
          scan_i_next   = adv_i;
          progress_next = adv_prog;
        end else begin
          mem_raddr = {cur_b, head[cur_b]};
          st_next   = S_CHKB;
        end
      end
      S_CHKB: begin
        if ((mem_rdata == cur_id) && free_a && free_b) begin
          cmd.grant         = 1'b1;
          cmd.a             = IDX_W'(cur_a);
          cmd.b             = IDX_W'(cur_b);
          head_next[cur_a]  = head[cur_a] + QSLOT_W'(1);
          head_next[cur_b]  = head[cur_b] + QSLOT_W'(1);
          count_next[cur_a] = count[cur_a] - CNT_W'(1);
          count_next[cur_b] = count[cur_b] - CNT_W'(1);
          ngr_next          = ngr + NGR_W'(1);
          progress_next     = 1'b1;
          st_next           = S_EMIT;
        end else begin
          st_next       = adv_st;
          scan_i_next   = adv_i;
          progress_next = adv_prog;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_grant     = 1'b1;
          st_next       = adv_st;
          scan_i_next   = adv_i;
          progress_next = adv_prog;
        end
      end
      S_STAT: begin
        if (slot_free) begin
          out_load = 1'b1;
          st_next  = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      scan_i   <= '0;
      progress <= 1'b0;
      ngr      <= '0;
      cooldown <= '0;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        head[r]  <= '0;
        count[r] <= '0;
      end
    end else begin
      st       <= st_next;
      scan_i   <= scan_i_next;
      progress <= progress_next;
      ngr      <= ngr_next;
      head     <= head_next;
      count    <= count_next;
      if (psel && penable && pwrite && !paddr[PADDR_W-1]) begin
        cooldown <= pwdata[COOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    stat   <= stat_next;
    cur_id <= cur_id_next;
    cur_a  <= cur_a_next;
    cur_b  <= cur_b_next;
    if (pend_we) begin
      pend_l[in_ch.requester_id] <= la;
      pend_r[in_ch.requester_id] <= lb;
    end
  end

  // output register: a finished beat waits here while the core moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.is_grant   <= out_grant;
      out_ch.granted_id <= out_grant ? cur_id : '0;
      out_ch.status     <= out_grant ? ST_OK : stat;
      out_ch.last       <= !out_grant;
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[PADDR_W-1] ? '0 : {{(PDATA_W - COOL_W){1'b0}}, cooldown};

  fpra_qram #(
    .DEPTH (NUM_RESOURCES * QUEUE_DEPTH),
    .AW    (RA_W)
  ) u_qram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fpra_res #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .RIDX_W        (RIDX_W)
  ) u_res (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cooldown (cooldown),
    .qa       (cur_a),
    .qb       (cur_b),
    .free_a   (free_a),
    .free_b   (free_b)
  );

endmodule
`default_nettype wire

// ===== sv/fpra_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fpra_check import fpra_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                ov,
  input wire logic                ordy,
  input wire logic                ogrant,
  input wire logic [ID_W-1:0]     oid,
  input wire logic [STATUS_W-1:0] ostat,
  input wire logic                olast,
  input wire logic                pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ov && !ordy |=> ov && $stable(oid) && $stable(olast))
    else $error("output beat dropped while stalled");

  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    ov && !ogrant |-> olast && (oid == '0))
    else $error("status beat malformed");

  a_grant_beat: assert property (@(posedge clk) disable iff (rst)
    ov && ogrant |-> !olast && (ostat == ST_OK))
    else $error("grant beat malformed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind fifo_paired_resource_arbiter_core fpra_check u_fpra_check (
  .clk    (clk),
  .rst    (rst),
  .ov     (out_ch.valid),
  .ordy   (out_ch.ready),
  .ogrant (out_ch.is_grant),
  .oid    (out_ch.granted_id),
  .ostat  (out_ch.status),
  .olast  (out_ch.last),
  .pready (pready)
);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import fpra_pkg::*;

  localparam int NRES = NUM_RESOURCES_DEF;
  localparam int NREQ = NUM_REQUESTERS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   rid;
    logic [IDX_W-1:0]  lft;
    logic [IDX_W-1:0]  rgt;
  } arb_op_t;

  typedef struct packed {
    logic                is_grant;
    logic [ID_W-1:0]     gid;
    logic [STATUS_W-1:0] status;
    logic                last;
  } arb_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  fpra_in_if  in_ch ();
  fpra_out_if out_ch ();

  fifo_paired_resource_arbiter_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the arbiter state
  logic [15:0]       cool_ticks;
  busy_t             res_state [NRES];
  logic [TIME_W-1:0] res_deadline [NRES];
  logic [ID_W-1:0]   fifo_mem [NRES][QUEUE_DEPTH];
  int                fifo_head [NRES];
  int                fifo_cnt [NRES];
  logic [IDX_W-1:0]  want_l [NREQ];
  logic [IDX_W-1:0]  want_r [NREQ];
  logic [TIME_W-1:0] tick_now;

  arb_op_t   pending_ops [$];
  arb_beat_t expected_beats [$];
  int  send_idle_pct = 0, recv_idle_pct = 0;
  bit  recv_hold = 0;
  int  errors = 0, n_ops = 0, n_grants = 0, n_flags = 0;
  longint cycles = 0;

  function automatic bit res_is_free(int r);
    return res_state[r] == BUSY_FREE ||
           (res_state[r] == BUSY_COOL && res_deadline[r] <= tick_now);
  endfunction

  function automatic bit at_head(int r, int id);
    return fifo_cnt[r] != 0 && fifo_mem[r][fifo_head[r]] == id;
  endfunction

  function automatic void take_head(int r);
    fifo_head[r] = (fifo_head[r] + 1) % QUEUE_DEPTH;
    fifo_cnt[r]--;
  endfunction

  function automatic void clear_shadow();
    cool_ticks = '0;
    tick_now = '0;
    for (int r = 0; r < NRES; r++) begin
      res_state[r] = BUSY_FREE;
      res_deadline[r] = '0;
      fifo_head[r] = 0;
      fifo_cnt[r] = 0;
    end
    for (int q = 0; q < NREQ; q++) begin
      want_l[q] = '0;
      want_r[q] = '0;
    end
  endfunction

  // apply one op and queue the grant beats plus the closing status beat
  function automatic void predict_arbitration(arb_op_t op);
    status_t st;
    logic [32:0] dl;
    int ng, id, a, b;
    bit progress;
    st = ST_OK;
    ng = 0;
    if (op.kind == KIND_REQ || op.kind == KIND_REL) begin
      if (op.rid >= NREQ || op.lft >= NRES || op.rgt >= NRES) st = ST_RANGE;
      else if (op.lft == op.rgt) st = ST_EQUAL;
      else if (op.kind == KIND_REQ) begin
        if (fifo_cnt[op.lft] >= QUEUE_DEPTH || fifo_cnt[op.rgt] >= QUEUE_DEPTH) st = ST_FULL;
        else begin
          want_l[op.rid] = op.lft;
          want_r[op.rid] = op.rgt;
          fifo_mem[op.lft][(fifo_head[op.lft] + fifo_cnt[op.lft]) % QUEUE_DEPTH] = op.rid;
          fifo_cnt[op.lft]++;
          fifo_mem[op.rgt][(fifo_head[op.rgt] + fifo_cnt[op.rgt]) % QUEUE_DEPTH] = op.rid;
          fifo_cnt[op.rgt]++;
        end
      end else begin
        dl = {1'b0, tick_now} + cool_ticks;
        if (dl[32]) dl = 33'hFFFF_FFFF;
        res_state[op.lft] = BUSY_COOL;
        res_state[op.rgt] = BUSY_COOL;
        res_deadline[op.lft] = dl[31:0];
        res_deadline[op.rgt] = dl[31:0];
      end
    end else if (op.kind == KIND_TICK) begin
      if (tick_now != 32'hFFFF_FFFF) tick_now++;
    end
    if (st != ST_OK) n_flags++;
    do begin
      progress = 0;
      for (int i = 0; i < NRES; i++) begin
        if (ng >= MAX_GRANTS) break;
        if (fifo_cnt[i] == 0) continue;
        id = fifo_mem[i][fifo_head[i]];
        a = want_l[id];
        b = want_r[id];
        if (a >= NRES || b >= NRES || a == b) continue;
        if (!at_head(a, id) || !at_head(b, id)) continue;
        if (!res_is_free(a) || !res_is_free(b)) continue;
        res_state[a] = BUSY_USED;
        res_state[b] = BUSY_USED;
        take_head(a);
        take_head(b);
        expected_beats.push_back('{1'b1, id[ID_W-1:0], ST_OK, 1'b0});
        ng++;
        progress = 1;
      end
    end while (progress && ng < MAX_GRANTS);
    n_grants += ng;
    expected_beats.push_back('{1'b0, '0, st, 1'b1});
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= '0;
      in_ch.requester_id <= '0;
      in_ch.left_index <= '0;
      in_ch.right_index <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_arbitration('{in_ch.kind, in_ch.requester_id, in_ch.left_index,
                              in_ch.right_index});
        n_ops++;
      end
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        arb_op_t op;
        op = pending_ops.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= op.kind;
        in_ch.requester_id <= op.rid;
        in_ch.left_index <= op.lft;
        in_ch.right_index <= op.rgt;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        arb_beat_t exp_b;
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: is_grant=%0d granted_id=%0d status=%0d last=%0d",
                 out_ch.is_grant, out_ch.granted_id, out_ch.status, out_ch.last);
          errors++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (out_ch.is_grant !== exp_b.is_grant) begin
            $error("is_grant: expected %0d actual %0d", exp_b.is_grant, out_ch.is_grant);
            errors++;
          end
          if (out_ch.granted_id !== exp_b.gid) begin
            $error("granted_id: expected %0d actual %0d", exp_b.gid, out_ch.granted_id);
            errors++;
          end
          if (out_ch.status !== exp_b.status) begin
            $error("status: expected %0d actual %0d", exp_b.status, out_ch.status);
            errors++;
          end
          if (out_ch.last !== exp_b.last) begin
            $error("last: expected %0d actual %0d", exp_b.last, out_ch.last);
            errors++;
          end
        end
      end
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_cooldown(input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cool_ticks = val;
  endtask

  // sampled mid-cycle so the driver's and monitor's updates have settled
  task automatic drain_all();
    while (pending_ops.size() != 0 || in_ch.valid || expected_beats.size() != 0)
      @(negedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic push_op(input kind_t k, input int id, input int l, input int r);
    pending_ops.push_back('{k, id[ID_W-1:0], l[IDX_W-1:0], r[IDX_W-1:0]});
  endtask

  // mostly legal requests, releases of random pairs and ticks
  task automatic add_random_ops(input int count);
    int sel, l, r;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      l = $urandom_range(NRES - 1);
      r = (l + 1 + $urandom_range(NRES - 2)) % NRES;
      if (sel < 40) push_op(KIND_REQ, $urandom_range(15), l, r);
      else if (sel < 65) push_op(KIND_REL, $urandom_range(15), l, r);
      else if (sel < 88) push_op(KIND_TICK, $urandom, $urandom, $urandom);
      else pending_ops.push_back(arb_op_t'($urandom));
    end
  endtask

  initial begin
    clear_shadow();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_cooldown(16'd0);
    // directed: extremes, flags, every kind
    push_op(KIND_REQ, 0, 0, 1);
    push_op(KIND_REQ, 15, 1, 7);
    push_op(KIND_REL, 0, 0, 1);
    push_op(KIND_REQ, 3, 8, 2);
    push_op(KIND_REQ, 3, 2, 15);
    push_op(KIND_REL, 3, 9, 1);
    push_op(KIND_REQ, 4, 5, 5);
    push_op(KIND_REL, 4, 6, 6);
    push_op(KIND_TICK, 15, 15, 15);
    push_op(KIND_NONE, 10, 5, 10);
    push_op(KIND_REL, 15, 1, 7);
    push_op(KIND_REQ, 5, 2, 3);
    push_op(KIND_REQ, 5, 4, 6);  // repeated request overwrites its pair
    push_op(KIND_REQ, 6, 3, 4);
    push_op(KIND_REL, 9, 2, 3);  // release by anyone
    drain_all();

    write_cooldown(16'd3);
    // resource 6 is still in use, so the first 16 fill the queues and the last two find them full
    for (int k = 0; k < 18; k++) push_op(KIND_REQ, k % 16, 6, 7);
    for (int k = 0; k < 4; k++) push_op(KIND_REL, 0, 6, 7);
    for (int k = 0; k < 8; k++) push_op(KIND_TICK, 0, 0, 0);
    drain_all();

    send_idle_pct = 29; recv_idle_pct = 70;
    add_random_ops(130);
    drain_all();

    write_cooldown(16'hFFFF);
    send_idle_pct = 70; recv_idle_pct = 29;
    add_random_ops(130);
    // sender pauses until every result has come
    drain_all();

    write_cooldown(16'd1);
    send_idle_pct = 0; recv_idle_pct = 0;
    add_random_ops(140);
    // receiver holds off for a long stretch in its own process
    fork
      begin
        recv_hold = 1;
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
    join_none
    drain_all();

    $display("ran %0d ops: %0d grants, %0d flagged ops, cooldown values 0/3/65535/1",
             n_ops, n_grants, n_flags);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/fpra_pkg.sv
sv/fpra_if.sv
sv/fpra_qram.sv
sv/fpra_res.sv
sv/fifo_paired_resource_arbiter_core.sv
sv/fpra_check.sv
test/testbench.sv
